// File: rtl/bcre_pkg.sv
// Shared types, constants and register codes for the crop-and-rotate frame engine.
// Used by every module of the block except bcre_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bcre_pkg;

  // Field widths fixed by the register map and the pixel format.
  localparam int DIM_W     = 9;
  localparam int POS_W     = 8;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int BYTES_W   = 19;
  localparam int CFG_IDX_W = 3;

  // Largest dimension that a configuration register can express.
  localparam int DIM_LIMIT = (1 << DIM_W) - 1;

  // Defaults and fixed constants of the output file format.
  localparam int DEF_MAX_DIM  = 256;
  localparam int HEADER_BYTES = 54;
  localparam int ROW_ALIGN    = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_HEIGHT   = 3'd5;

  // Command codes of an incoming request.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  // Window check results.
  localparam logic [1:0] STAT_OK             = 2'd0;
  localparam logic [1:0] STAT_POINT_OUTSIDE  = 2'd1;
  localparam logic [1:0] STAT_ZERO_SIZE      = 2'd2;
  localparam logic [1:0] STAT_SECOND_OUTSIDE = 2'd3;

  // Incoming request payload.
  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  // Outgoing result payload.
  typedef struct packed {
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic               last;
    logic [1:0]         status;
    logic [BYTES_W-1:0] image_bytes;
    logic [BYTES_W-1:0] file_bytes;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ADDR,
    ST_READ,
    ST_SEND
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic prep;
    logic step;
    logic read;
    logic send;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_emit;
    logic win_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/bmp_crop_rotate_engine_unit.sv
// Top level of the crop-and-rotate frame engine: controller and datapath.
// Depends on bcre_pkg, bcre_ctrl, bcre_dp and bcre_ram.
//
//   Channel   Dir  Handshake             Payload
//   cmd       in   cmd_valid/cmd_stall   in_item_t  (load pixel or emit request)
//   pix       out  pix_valid/pix_stall   out_item_t (rotated pixel and sizes)
//   cfg       in   cfg_write             cfg_index, cfg_data
//
// A load request passes the states PREP and ADDR before the next request can be
// accepted; an emit passes PREP, ADDR, READ and SEND, skipping READ when the window
// check fails, and SEND waits while the result register is held by pix_stall. The steps
// are the two multiply steps (pixel count, then source address) and the registered read.
// Synchronous reset clears the control state, the configuration registers and the
// position counters; the frame store is not cleared and holds no data until loaded.
`timescale 1ns / 1ps
`default_nettype none

module bmp_crop_rotate_engine_unit #(
  parameter int MAX_DIM = bcre_pkg::DEF_MAX_DIM
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  output logic                                cmd_stall,
  input  wire bcre_pkg::in_item_t             cmd_item,
  output logic                                pix_valid,
  input  wire logic                           pix_stall,
  output bcre_pkg::out_item_t                 pix_item,
  input  wire logic                           cfg_write,
  input  wire logic [bcre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bcre_pkg::DIM_W-1:0]     cfg_data
);

  import bcre_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // Sequencer.
  bcre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Arithmetic, frame store and result register.
  bcre_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_item  (cmd_item),
    .ctl       (ctl),
    .stat      (stat),
    .pix_item  (pix_item)
  );

  // Only one request is in work at a time.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("request accepted while another is in work");

  // A result appears only after the controller has sent one.
  a_valid_from_send: assert property (@(posedge clk) disable iff (rst)
    $rose(pix_valid) |-> $past(ctl.send))
    else $error("result valid without a send command");

  // A failed window carries no pixel, no last mark and no sizes.
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_item.status != STAT_OK) |->
      (!pix_item.last && pix_item.image_bytes == '0 && pix_item.file_bytes == '0))
    else $error("error result carries data");

endmodule

`default_nettype wire

// File: rtl/bcre_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module bcre_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bcre_ctrl.sv
// Controller of the crop-and-rotate engine: sequences one request at a time.
// Depends on bcre_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module bcre_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  output logic                    pix_valid,
  input  wire logic               pix_stall,
  input  wire bcre_pkg::dp_stat_t stat,
  output bcre_pkg::ctl_cmd_t      ctl
);

  import bcre_pkg::*;

  state_t state;
  state_t state_next;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pix_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.send) begin
        pix_valid <= 1'b1;
      end else if (pix_valid && !pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        priority if (!stat.is_emit) begin
          state_next = ST_IDLE;
        end else if (stat.win_ok) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_SEND;
        end
      end
      ST_READ: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (!pix_valid || !pix_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath and the request stall.
  always_comb begin
    cmd_stall   = (state != ST_IDLE);
    ctl.capture = (state == ST_IDLE) && cmd_valid;
    ctl.prep    = (state == ST_PREP);
    ctl.step    = (state == ST_ADDR);
    ctl.read    = (state == ST_READ);
    ctl.send    = (state == ST_SEND) && (!pix_valid || !pix_stall);
  end

endmodule

`default_nettype wire

// File: rtl/bcre_dp.sv
// Datapath of the crop-and-rotate engine: registers, window check, address
// arithmetic, frame store and result register. Depends on bcre_pkg and bcre_ram.
`timescale 1ns / 1ps
`default_nettype none

module bcre_dp #(
  parameter int MAX_DIM = bcre_pkg::DEF_MAX_DIM
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [bcre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcre_pkg::DIM_W-1:0]      cfg_data,
  input  wire bcre_pkg::in_item_t              cmd_item,
  input  wire bcre_pkg::ctl_cmd_t              ctl,
  output bcre_pkg::dp_stat_t                   stat,
  output bcre_pkg::out_item_t                  pix_item
);

  import bcre_pkg::*;

  // Sizes that follow from the largest frame.
  localparam int DIM_EFF = (MAX_DIM > DIM_LIMIT) ? DIM_LIMIT : MAX_DIM;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W   = (DIM_EFF > 1) ? $clog2(DIM_EFF * DIM_EFF) : 1;
  localparam int TOT_W   = 2 * DIM_W;
  localparam int SROW_W  = DIM_W + 1;
  localparam int SUM_W   = SROW_W + DIM_W;
  localparam int HP_W    = DIM_W + 2;
  localparam int IMG_W   = DIM_W + HP_W;
  localparam logic [DIM_W-1:0] DIM_CLAMP = DIM_W'(DIM_EFF);

  // Configuration registers.
  logic [DIM_W-1:0] source_width;
  logic [DIM_W-1:0] source_height;
  logic [POS_W-1:0] crop_left;
  logic [POS_W-1:0] crop_top;
  logic [DIM_W-1:0] crop_width;
  logic [DIM_W-1:0] crop_height;

  // Captured request and per-request working registers.
  logic               item_cmd;
  logic [PIX_W-1:0]   item_pix;
  logic [DIM_W-1:0]   sw;
  logic [TOT_W-1:0]   total;
  logic [1:0]         win_status;
  logic [HP_W-1:0]    hp;
  logic [SROW_W-1:0]  src_row;
  logic [DIM_W-1:0]   cur_row;
  logic [DIM_W-1:0]   cur_col;
  logic               is_last;
  logic [AW-1:0]      addr;
  logic [BYTES_W-1:0] img;

  // Persistent position state.
  logic [IDX_W-1:0] load_index;
  logic [DIM_W-1:0] emit_row;
  logic [DIM_W-1:0] emit_col;

  // Combinational intermediates.
  logic [DIM_W-1:0]  sw_c;
  logic [DIM_W-1:0]  sh_c;
  logic [1:0]        status_c;
  logic              stale_c;
  logic [DIM_W-1:0]  row_c;
  logic [DIM_W-1:0]  col_c;
  logic [IDX_W-1:0]  idx_eff;
  logic [TOT_W-1:0]  idx_inc;
  logic [SUM_W-1:0]  addr_sum;
  logic [IMG_W-1:0]  img_full;
  logic [PIX_W-1:0]  rdata;
  logic              ram_we;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= DIM_W'(1);
      source_height <= DIM_W'(1);
      crop_left     <= '0;
      crop_top      <= '0;
      crop_width    <= DIM_W'(1);
      crop_height   <= DIM_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_CROP_LEFT:     crop_left     <= cfg_data[POS_W-1:0];
        REG_CROP_TOP:      crop_top      <= cfg_data[POS_W-1:0];
        REG_CROP_WIDTH:    crop_width    <= cfg_data;
        REG_CROP_HEIGHT:   crop_height   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Source dimensions are limited to the frame store, then the window is checked.
  always_comb begin
    sw_c = (source_width > DIM_CLAMP) ? DIM_CLAMP : source_width;
    sh_c = (source_height > DIM_CLAMP) ? DIM_CLAMP : source_height;
    priority if (DIM_W'(crop_left) >= sw_c || DIM_W'(crop_top) >= sh_c) begin
      status_c = STAT_POINT_OUTSIDE;
    end else if (crop_width == '0 || crop_height == '0) begin
      status_c = STAT_ZERO_SIZE;
    end else if ((SROW_W'(crop_top) + SROW_W'(crop_height) > SROW_W'(sh_c)) ||
                 (SROW_W'(crop_left) + SROW_W'(crop_width) > SROW_W'(sw_c))) begin
      status_c = STAT_SECOND_OUTSIDE;
    end else begin
      status_c = STAT_OK;
    end
  end

  // Counters left outside the window by a register change restart at zero.
  always_comb begin
    stale_c = (emit_row >= crop_width) || (emit_col >= crop_height);
    row_c   = stale_c ? '0 : emit_row;
    col_c   = stale_c ? '0 : emit_col;
  end

  // Load position: a stale position falls back to entry zero.
  always_comb begin
    idx_eff = (TOT_W'(load_index) < total) ? load_index : '0;
    idx_inc = TOT_W'(idx_eff) + TOT_W'(1);
    ram_we  = ctl.step && (item_cmd == CMD_LOAD);
  end

  // Source address of the rotated pixel and the output image size.
  always_comb begin
    addr_sum = SUM_W'(src_row) * SUM_W'(sw) + SUM_W'(crop_left) + SUM_W'(cur_row);
    img_full = IMG_W'(crop_width) * IMG_W'(hp);
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_cmd <= cmd_item.cmd;
      item_pix <= {cmd_item.in_red, cmd_item.in_green, cmd_item.in_blue};
    end
  end

  // First step: pixel count, window status, source row and padded row length.
  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      sw         <= sw_c;
      total      <= TOT_W'(sw_c) * TOT_W'(sh_c);
      win_status <= status_c;
      cur_row    <= row_c;
      cur_col    <= col_c;
      src_row    <= SROW_W'(crop_top) + SROW_W'(crop_height) - SROW_W'(1) - SROW_W'(col_c);
      is_last    <= (row_c == crop_width - DIM_W'(1)) && (col_c == crop_height - DIM_W'(1));
      hp         <= HP_W'({crop_height, 1'b0}) + HP_W'(crop_height) +
                    HP_W'(crop_height % ROW_ALIGN);
    end
  end

  // Second step: address and image size for an emit.
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      addr <= AW'(addr_sum);
      img  <= img_full[BYTES_W-1:0];
    end
  end

  // Position state: load index moves on a load, emit counters on a good emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      emit_row   <= '0;
      emit_col   <= '0;
    end else begin
      if (ram_we) begin
        load_index <= (idx_inc >= total) ? '0 : IDX_W'(idx_inc);
      end
      if (ctl.send && win_status == STAT_OK) begin
        priority if (is_last) begin
          emit_row <= '0;
          emit_col <= '0;
        end else if (SROW_W'(cur_col) + SROW_W'(1) >= SROW_W'(crop_height)) begin
          emit_row <= cur_row + DIM_W'(1);
          emit_col <= '0;
        end else begin
          emit_row <= cur_row;
          emit_col <= cur_col + DIM_W'(1);
        end
      end
    end
  end

  // Frame store.
  bcre_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(idx_eff)),
    .wdata (item_pix),
    .re    (ctl.read),
    .raddr (addr),
    .rdata (rdata)
  );

  // Result register: a failed window gives its status and nothing else.
  always_ff @(posedge clk) begin
    if (ctl.send) begin
      pix_item.status <= win_status;
      if (win_status == STAT_OK) begin
        pix_item.out_red     <= rdata[3*CH_W-1:2*CH_W];
        pix_item.out_green   <= rdata[2*CH_W-1:CH_W];
        pix_item.out_blue    <= rdata[CH_W-1:0];
        pix_item.out_row     <= cur_row[POS_W-1:0];
        pix_item.out_col     <= cur_col[POS_W-1:0];
        pix_item.last        <= is_last;
        pix_item.image_bytes <= img;
        pix_item.file_bytes  <= BYTES_W'(img + BYTES_W'(HEADER_BYTES));
      end else begin
        pix_item.out_red     <= '0;
        pix_item.out_green   <= '0;
        pix_item.out_blue    <= '0;
        pix_item.out_row     <= '0;
        pix_item.out_col     <= '0;
        pix_item.last        <= 1'b0;
        pix_item.image_bytes <= '0;
        pix_item.file_bytes  <= '0;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    stat.is_emit = (item_cmd == CMD_EMIT);
    stat.win_ok  = (win_status == STAT_OK);
  end

endmodule

`default_nettype wire
